>>> rtl/udu_pkg.sv
// ----------------------------------------------------------------------------
// udu_pkg
// Shared types and constants for the UTF-8 decoder with uppercase mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package udu_pkg;

    localparam int unsigned ACC_W = 32;
    localparam int unsigned CP_W  = 16;
    localparam int unsigned LEN_W = 3;

    localparam logic [CP_W-1:0] CP_MAX = 16'hFFFF;

    // Sequence lengths that the uppercase mapping distinguishes.
    localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO = 3'd2;

    // One finished decode event handed from the front end to the back end.
    typedef struct packed {
        logic             trunc;
        logic [ACC_W-1:0] acc;
        logic [LEN_W-1:0] len;
    } udu_event_t;

    // Sequence length announced by a lead byte; zero for the end marker.
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        begin
            if (b == 8'h00) begin
                len = 3'd0;
            end else if (b < 8'hC0) begin
                len = 3'd1;
            end else if (b < 8'hE0) begin
                len = 3'd2;
            end else if (b < 8'hF0) begin
                len = 3'd3;
            end else if (b < 8'hF8) begin
                len = 3'd4;
            end else if (b < 8'hFC) begin
                len = 3'd5;
            end else begin
                len = 3'd6;
            end
            return len;
        end
    endfunction

    // Marker bits of the lead and continuation bytes, removed after assembly.
    function automatic logic [ACC_W-1:0] len_offset(input logic [LEN_W-1:0] len);
        logic [ACC_W-1:0] off;
        begin
            case (len)
                3'd2:    off = 32'h0000_3080;
                3'd3:    off = 32'h000E_2080;
                3'd4:    off = 32'h03C8_2080;
                3'd5:    off = 32'hFA08_2080;
                3'd6:    off = 32'h8208_2080;
                default: off = 32'h0000_0000;
            endcase
            return off;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/udu_front.sv
// ----------------------------------------------------------------------------
// udu_front
// Byte front end: tracks the sequence in progress and emits decode events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udu_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire logic [7:0]           byte_value,
    output udu_pkg::udu_event_t       evt,
    output logic                      evt_push
);

    logic [udu_pkg::ACC_W-1:0] acc_reg,    acc_next;
    logic [udu_pkg::LEN_W-1:0] left_reg,   left_next;
    logic [udu_pkg::LEN_W-1:0] seqlen_reg, seqlen_next;
    logic [udu_pkg::LEN_W-1:0] lead_len;
    logic [udu_pkg::ACC_W-1:0] acc_shift;

    assign lead_len  = udu_pkg::lead_length(byte_value);
    assign acc_shift = {acc_reg[udu_pkg::ACC_W-7:0], 6'b0} + {24'b0, byte_value};

    always_comb begin
        acc_next    = acc_reg;
        left_next   = left_reg;
        seqlen_next = seqlen_reg;
        evt_push    = 1'b0;
        evt.trunc   = 1'b0;
        evt.acc     = acc_shift;
        evt.len     = seqlen_reg;
        if (accept) begin
            if (left_reg == 3'd0) begin
                acc_next    = {24'b0, byte_value};
                seqlen_next = lead_len;
                evt.acc     = {24'b0, byte_value};
                evt.len     = lead_len;
                if (lead_len <= udu_pkg::LEN_ONE) begin
                    // End marker (acc zero, length zero) or a one-byte code.
                    evt_push = 1'b1;
                end else begin
                    left_next = lead_len - 3'd1;
                end
            end else if (byte_value == 8'h00) begin
                evt_push  = 1'b1;
                evt.trunc = 1'b1;
                evt.acc   = acc_reg;
                evt.len   = seqlen_reg - left_reg;
                left_next = 3'd0;
            end else begin
                acc_next  = acc_shift;
                left_next = left_reg - 3'd1;
                evt_push  = (left_reg == 3'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            left_reg   <= '0;
            seqlen_reg <= '0;
        end else begin
            acc_reg    <= acc_next;
            left_reg   <= left_next;
            seqlen_reg <= seqlen_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/udu_fifo.sv
// ----------------------------------------------------------------------------
// udu_fifo
// Short event queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udu_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  udu_pkg::udu_event_t       push_data,
    input  wire logic                 pop,
    output udu_pkg::udu_event_t       pop_data,
    output logic                      full,
    output logic                      empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    udu_pkg::udu_event_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/udu_back.sv
// ----------------------------------------------------------------------------
// udu_back
// Back end: removes the length offset, clamps, maps to uppercase and holds
// the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udu_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  udu_pkg::udu_event_t       evt,
    input  wire logic                 evt_valid,
    output logic                      evt_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [15:0]               m_code_point,
    output logic [15:0]               m_upper_code,
    output logic [2:0]                m_seq_length,
    output logic                      m_truncated
);

    logic [udu_pkg::ACC_W-1:0] diff;
    logic [udu_pkg::CP_W-1:0]  cp;
    logic [udu_pkg::CP_W-1:0]  upper;
    logic [udu_pkg::CP_W-1:0]  cp_res, upper_res;

    logic                      valid_reg, valid_next;
    logic [udu_pkg::CP_W-1:0]  code_reg, upper_reg;
    logic [udu_pkg::LEN_W-1:0] len_reg;
    logic                      trunc_reg;

    assign diff = evt.acc - udu_pkg::len_offset(evt.len);
    assign cp   = (diff[udu_pkg::ACC_W-1:udu_pkg::CP_W] != '0) ?
                  udu_pkg::CP_MAX : diff[udu_pkg::CP_W-1:0];

    always_comb begin
        upper = cp;
        if (evt.len == udu_pkg::LEN_ONE) begin
            if (cp >= 16'h0061 && cp <= 16'h007A) begin
                upper = cp - 16'd32;
            end
        end else if (evt.len == udu_pkg::LEN_TWO) begin
            if (cp >= 16'h00E0 && cp <= 16'h00FE) begin
                upper = cp - 16'd32;
            end else if (cp == 16'd339) begin
                upper = 16'd338;
            end else if (cp == 16'd1105) begin
                upper = 16'd1025;
            end else if (cp >= 16'h0430 && cp <= 16'h044F) begin
                upper = cp - 16'd32;
            end
        end
    end

    // A truncated sequence reports the raw partial value with no mapping.
    assign cp_res    = evt.trunc ? evt.acc[udu_pkg::CP_W-1:0] : cp;
    assign upper_res = evt.trunc ? '0 : upper;

    assign evt_pop = evt_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (evt_pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_pop) begin
            code_reg  <= cp_res;
            upper_reg <= upper_res;
            len_reg   <= evt.len;
            trunc_reg <= evt.trunc;
        end
    end

    assign m_valid      = valid_reg;
    assign m_code_point = code_reg;
    assign m_upper_code = upper_reg;
    assign m_seq_length = len_reg;
    assign m_truncated  = trunc_reg;

endmodule

`default_nettype wire

>>> rtl/utf8_decode_uppercase.sv
// ----------------------------------------------------------------------------
// utf8_decode_uppercase
// UTF-8 byte stream decoder that reports each code point with its uppercase
// form.
//
// The s_ channel takes one byte per transaction; a zero byte marks the end
// of the text. The m_ channel delivers one transaction for every completed
// sequence, every zero byte, and every sequence cut short by a zero byte
// (then with m_truncated set and the raw partial value).
// When a byte that finishes a result is accepted, the front end pushes the
// event into the queue at that edge; the back end then loads it from the
// queue into the output register, which raises m_valid, once that register
// is free or being read. One byte is taken every cycle while the queue is
// not full: the accumulator update in the front end is a single shift and
// add, and the back end drains one event per cycle while m_ready is high.
// When the receiver holds m_ready low the output register holds its
// transaction, the queue fills behind it and s_ready falls once the queue
// is full. Reset empties the queue and the output register and returns the
// decoder to the idle state with a cleared accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_decode_uppercase #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_byte_value,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [15:0]       m_code_point,
    output logic [15:0]       m_upper_code,
    output logic [2:0]        m_seq_length,
    output logic              m_truncated
);

    udu_pkg::udu_event_t front_evt;
    udu_pkg::udu_event_t queue_evt;
    logic                front_push;
    logic                queue_full;
    logic                queue_empty;
    logic                back_pop;
    logic                accept;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    udu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .byte_value (s_byte_value),
        .evt        (front_evt),
        .evt_push   (front_push)
    );

    udu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_data (front_evt),
        .pop       (back_pop),
        .pop_data  (queue_evt),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    udu_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .evt          (queue_evt),
        .evt_valid    (!queue_empty),
        .evt_pop      (back_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_upper_code (m_upper_code),
        .m_seq_length (m_seq_length),
        .m_truncated  (m_truncated)
    );

endmodule

`default_nettype wire
